// ----- hw/rtl/supply_capacitance_estimator_defines.svh -----
// assertion macros shared by the supply capacitance estimator rtl
// expects aclk and aresetn in the scope of each use
`ifndef SUPPLY_CAPACITANCE_ESTIMATOR_DEFINES_SVH
`define SUPPLY_CAPACITANCE_ESTIMATOR_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SCE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define SCE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sce_pkg.sv -----
// shared types, constants and microcode table of the capacitance estimator
// no dependencies
`default_nettype none

package sce_pkg;

    // data widths
    localparam int unsigned DATA_W    = 32;
    localparam int unsigned UDATA_W   = 31;
    localparam int unsigned GAIN_W    = 17;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DIV_NUM_W = 2 * DIV_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_W);
    localparam int unsigned STEP_W    = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd2;

    // fixed point constants
    localparam logic [GAIN_W-1:0]  Q_ONE = 17'h1_0000;
    localparam logic [UDATA_W-1:0] MAX31 = 31'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  MAX32 = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0]  MIN32 = 32'h8000_0000;

    typedef logic [STEP_W-1:0] step_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_AVG    = 3'd0,
        OP_MUL    = 3'd1,
        OP_LOAD_T = 3'd2,
        OP_DIV    = 3'd3,
        OP_FMUL   = 3'd4,
        OP_FADD   = 3'd5,
        OP_LOAD_C = 3'd6,
        OP_FINISH = 3'd7
    } op_t;

    // sequencing kinds
    typedef enum logic [2:0] {
        JMP_NEXT = 3'd0,
        JMP_SKIP = 3'd1,
        JMP_LOOP = 3'd2,
        JMP_DTZ  = 3'd3,
        JMP_END  = 3'd4
    } jmp_t;

    typedef struct packed {
        op_t   op;
        jmp_t  jmp;
        step_t target;
    } ucode_t;

    // sequencer to datapath
    typedef struct packed {
        logic start;
        logic run;
        op_t  op;
    } sce_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic update;
        logic dt_zero;
        logic div_last;
        logic out_full;
    } sce_status_t;

    // program steps
    localparam step_t U_AVG  = 4'd0;
    localparam step_t U_MUL  = 4'd1;
    localparam step_t U_LDT  = 4'd2;
    localparam step_t U_DIVT = 4'd3;
    localparam step_t U_FMUL = 4'd4;
    localparam step_t U_FADD = 4'd5;
    localparam step_t U_LDC  = 4'd6;
    localparam step_t U_DIVC = 4'd7;
    localparam step_t U_FIN  = 4'd8;

    // control store
    function automatic ucode_t sce_ucode(input step_t pc);
        ucode_t w;
        unique case (pc)
            U_AVG:   w = '{op: OP_AVG,    jmp: JMP_NEXT, target: U_AVG};
            U_MUL:   w = '{op: OP_MUL,    jmp: JMP_SKIP, target: U_LDC};
            U_LDT:   w = '{op: OP_LOAD_T, jmp: JMP_NEXT, target: U_LDT};
            U_DIVT:  w = '{op: OP_DIV,    jmp: JMP_LOOP, target: U_DIVT};
            U_FMUL:  w = '{op: OP_FMUL,   jmp: JMP_NEXT, target: U_FMUL};
            U_FADD:  w = '{op: OP_FADD,   jmp: JMP_NEXT, target: U_FADD};
            U_LDC:   w = '{op: OP_LOAD_C, jmp: JMP_DTZ,  target: U_FIN};
            U_DIVC:  w = '{op: OP_DIV,    jmp: JMP_LOOP, target: U_DIVC};
            U_FIN:   w = '{op: OP_FINISH, jmp: JMP_END,  target: U_FIN};
            default: w = '{op: OP_FINISH, jmp: JMP_END,  target: U_FIN};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/supply_capacitance_estimator.sv -----
// Supply capacitance estimator. One transaction per simulation frame: it
// updates two-frame averages of demand and supply pressure, moves a filtered
// capacitance estimate when the averaged pressure change exceeds the
// threshold, and returns the effective conductivity (unsigned Q15.16), the
// estimate and the pressure change (signed Q16.16). A microcoded sequencer
// steps a datapath with one 32x31 product multiplier, one 18x33 gain
// multiplier and one radix-2 divider that yields one quotient bit per cycle.
// The divider runs once for the estimate target when an update happens and
// once for the conductivity when the time step is nonzero. The next
// transaction is taken the cycle after the result is written, while the
// result register may still wait for m_ready.
// depends on sce_pkg, sce_sequencer, sce_datapath
`default_nettype none

module supply_capacitance_estimator import sce_pkg::*; (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [DATA_W-1:0]    s_demand_flux,
    input  wire logic signed [DATA_W-1:0]    s_supply_pressure,
    input  wire logic        [UDATA_W-1:0]   s_time_step,
    input  wire logic        [UDATA_W-1:0]   s_given_capacitance,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic             [UDATA_W-1:0]   m_conductivity,
    output logic signed      [DATA_W-1:0]    m_capacitance_estimate,
    output logic signed      [DATA_W-1:0]    m_pressure_change,
    input  wire logic                        cfg_wr_en,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [UDATA_W-1:0]   cfg_wr_data
);

    sce_ctrl_t   ctrl;
    sce_status_t status;

    // control store sequencer
    sce_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    // arithmetic and state
    sce_datapath u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .ctrl                   (ctrl),
        .status                 (status),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_index              (cfg_index),
        .cfg_wr_data            (cfg_wr_data),
        .s_demand_flux          (s_demand_flux),
        .s_supply_pressure      (s_supply_pressure),
        .s_time_step            (s_time_step),
        .s_given_capacitance    (s_given_capacitance),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_conductivity         (m_conductivity),
        .m_capacitance_estimate (m_capacitance_estimate),
        .m_pressure_change      (m_pressure_change)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/sce_sequencer.sv -----
// step counter and control store walker of the capacitance estimator
// depends on sce_pkg and the shared assertion macros
`default_nettype none
`include "supply_capacitance_estimator_defines.svh"

module sce_sequencer import sce_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire sce_status_t status,
    output sce_ctrl_t        ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t state_reg, state_next;
    step_t  pc_reg, pc_next;
    ucode_t word;

    assign word    = sce_ucode(pc_reg);
    assign s_ready = (state_reg == ST_IDLE);

    // control word to the datapath
    always_comb begin
        ctrl.start = s_valid && s_ready;
        ctrl.run   = (state_reg == ST_RUN);
        ctrl.op    = word.op;
    end

    // next step selection
    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_RUN;
                    pc_next    = U_AVG;
                end
            end
            ST_RUN: begin
                unique case (word.jmp)
                    JMP_NEXT: pc_next = step_t'(pc_reg + 1'b1);
                    JMP_SKIP: pc_next = status.update ? step_t'(pc_reg + 1'b1) : word.target;
                    JMP_LOOP: pc_next = status.div_last ? step_t'(pc_reg + 1'b1) : word.target;
                    JMP_DTZ:  pc_next = status.dt_zero ? word.target : step_t'(pc_reg + 1'b1);
                    JMP_END: begin
                        if (!status.out_full) begin
                            state_next = ST_IDLE;
                        end
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= U_AVG;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    // a full result register holds the final step in place
    `SCE_ASSERT_NXT(a_finish_stall,
        ctrl.run && word.op == OP_FINISH && status.out_full,
        state_reg == ST_RUN && pc_reg == $past(pc_reg),
        "finish step left while result register full")

    // divider loop repeats until its last bit
    `SCE_ASSERT_NXT(a_div_loop,
        ctrl.run && word.op == OP_DIV && !status.div_last,
        state_reg == ST_RUN && pc_reg == $past(pc_reg),
        "divider loop left early")

endmodule

`default_nettype wire

// ----- hw/rtl/sce_divider.sv -----
// radix-2 restoring divider, 64 by 32 bits, 32 bits of quotient
// depends on sce_pkg and the shared assertion macros
`default_nettype none
`include "supply_capacitance_estimator_defines.svh"

module sce_divider import sce_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire logic                 step,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_W-1:0]     den,
    output logic      [DIV_W-1:0]     quo,
    output logic                      ovf,
    output logic                      last
);

    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     work_reg;
    logic [DIV_W-1:0]     den_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 loaded_reg;

    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       trial_diff;
    logic                 fits;

    // one quotient bit per step
    assign trial      = {rem_reg, work_reg[DIV_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign fits       = (trial >= {1'b0, den_reg});

    assign quo  = work_reg;
    assign ovf  = ovf_reg;
    assign last = (cnt_reg == DIV_CNT_W'(DIV_W - 1));

    // counter and load marker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            loaded_reg <= 1'b0;
        end else if (load) begin
            cnt_reg    <= '0;
            loaded_reg <= 1'b1;
        end else if (step) begin
            cnt_reg <= DIV_CNT_W'(cnt_reg + 1'b1);
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg  <= num[DIV_NUM_W-1:DIV_W];
            work_reg <= num[DIV_W-1:0];
            den_reg  <= den;
            ovf_reg  <= (num[DIV_NUM_W-1:DIV_W] >= den);
        end else if (step) begin
            rem_reg  <= fits ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
            work_reg <= {work_reg[DIV_W-2:0], fits};
        end
    end

    // partial remainder never reaches the divisor
    `SCE_ASSERT_IMP(a_rem_below,
        loaded_reg && !ovf_reg && den_reg != '0,
        rem_reg < den_reg,
        "partial remainder reached the divisor")

endmodule

`default_nettype wire

// ----- hw/rtl/sce_datapath.sv -----
// registers, multipliers, filter arithmetic and result register of the estimator
// depends on sce_pkg, sce_divider and the shared assertion macros
`default_nettype none
`include "supply_capacitance_estimator_defines.svh"

module sce_datapath import sce_pkg::*; (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sce_ctrl_t                   ctrl,
    output sce_status_t                      status,
    input  wire logic                        cfg_wr_en,
    input  wire logic        [CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [UDATA_W-1:0]   cfg_wr_data,
    input  wire logic signed [DATA_W-1:0]    s_demand_flux,
    input  wire logic signed [DATA_W-1:0]    s_supply_pressure,
    input  wire logic        [UDATA_W-1:0]   s_time_step,
    input  wire logic        [UDATA_W-1:0]   s_given_capacitance,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic             [UDATA_W-1:0]   m_conductivity,
    output logic signed      [DATA_W-1:0]    m_capacitance_estimate,
    output logic signed      [DATA_W-1:0]    m_pressure_change
);

    localparam int unsigned PROD_W  = DATA_W + UDATA_W;
    localparam int unsigned FPROD_W = GAIN_W + 1 + DATA_W + 1;
    localparam int unsigned FSUM_W  = FPROD_W - 16 + 1;

    // configuration
    logic [UDATA_W-1:0] min_cond_reg;
    logic [UDATA_W-1:0] min_dp_reg;
    logic [GAIN_W-1:0]  gain_reg;

    // frame inputs
    logic [DATA_W-1:0]  flux_reg;
    logic [DATA_W-1:0]  press_reg;
    logic [UDATA_W-1:0] dt_reg;
    logic [UDATA_W-1:0] cap_reg;

    // running state
    logic [DATA_W-1:0]  avg_dem_reg;
    logic [DATA_W-1:0]  avg_press_reg;
    logic [DATA_W-1:0]  est_reg;
    logic [DATA_W-1:0]  change_reg;

    // work registers
    logic [PROD_W-1:0]  prod_reg;
    logic [FPROD_W-1:0] fprod_reg;
    logic               neg_reg;

    // result register
    logic               m_valid_reg;
    logic [UDATA_W-1:0] cond_reg;
    logic [DATA_W-1:0]  est_out_reg;
    logic [DATA_W-1:0]  change_out_reg;

    logic               fin_fire;
    logic               out_full;

    logic [DATA_W:0]    dem_sum;
    logic [DATA_W:0]    press_sum;
    logic [DATA_W-1:0]  avg_dem_next;
    logic [DATA_W-1:0]  avg_press_next;
    logic [DATA_W:0]    press_diff;
    logic [DATA_W-1:0]  change_next;

    logic [DATA_W-1:0]  change_mag;
    logic [DATA_W-1:0]  est_mag;
    logic [DATA_W-1:0]  dem_mag;
    logic               dem_pos;

    logic [PROD_W-1:0]  prod_next;
    logic [GAIN_W-1:0]  gain_clip;
    logic [DATA_W-1:0]  target;
    logic signed [DATA_W:0]      delta;
    logic signed [FPROD_W-1:0]   fprod_next;
    logic [FSUM_W-1:0]  fsum;
    logic [DATA_W-1:0]  est_next;

    logic               div_load;
    logic               div_step;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_W-1:0]   div_den;
    logic [DIV_W-1:0]   div_quo;
    logic               div_ovf;
    logic               div_last;

    logic [UDATA_W-1:0] quo_sat31;
    logic [UDATA_W-1:0] cond_next;

    // saturate a 36-bit two's complement value to 32 bits
    function automatic logic [DATA_W-1:0] sat_fsum(input logic [FSUM_W-1:0] v);
        logic [FSUM_W-1:0] r;
        r = v;
        if (r[FSUM_W-1] && (&r[FSUM_W-2:DATA_W-1]) == 1'b0) begin
            return MIN32;
        end else if (!r[FSUM_W-1] && (|r[FSUM_W-2:DATA_W-1])) begin
            return MAX32;
        end
        return r[DATA_W-1:0];
    endfunction

    // two-frame averages, floor of the halved sum
    assign dem_sum        = {flux_reg[DATA_W-1], flux_reg} + {avg_dem_reg[DATA_W-1], avg_dem_reg};
    assign press_sum      = {press_reg[DATA_W-1], press_reg}
                          + {avg_press_reg[DATA_W-1], avg_press_reg};
    assign avg_dem_next   = dem_sum[DATA_W:1];
    assign avg_press_next = press_sum[DATA_W:1];
    assign press_diff     = {avg_press_next[DATA_W-1], avg_press_next}
                          - {avg_press_reg[DATA_W-1], avg_press_reg};

    // pressure change, saturated
    always_comb begin
        if (press_diff[DATA_W] != press_diff[DATA_W-1]) begin
            change_next = press_diff[DATA_W] ? MIN32 : MAX32;
        end else begin
            change_next = press_diff[DATA_W-1:0];
        end
    end

    // magnitudes
    assign change_mag = change_reg[DATA_W-1]  ? DATA_W'(-change_reg)  : change_reg;
    assign est_mag    = est_reg[DATA_W-1]     ? DATA_W'(-est_reg)     : est_reg;
    assign dem_mag    = avg_dem_reg[DATA_W-1] ? DATA_W'(-avg_dem_reg) : avg_dem_reg;
    assign dem_pos    = !avg_dem_reg[DATA_W-1] && (avg_dem_reg != '0);

    // demand times step
    assign prod_next = PROD_W'(dem_mag) * PROD_W'(dt_reg);

    // target from signed quotient, saturated to 32 bits
    always_comb begin
        if (neg_reg) begin
            target = (div_ovf || div_quo > MIN32) ? MIN32 : DATA_W'(-div_quo);
        end else begin
            target = (div_ovf || div_quo[DIV_W-1]) ? MAX32 : div_quo;
        end
    end

    // first-order filter: est + floor(g * (target - est) / 1.0)
    assign gain_clip  = (gain_reg > Q_ONE) ? Q_ONE : gain_reg;
    assign delta      = $signed({target[DATA_W-1], target}) - $signed({est_reg[DATA_W-1], est_reg});
    assign fprod_next = $signed({1'b0, gain_clip}) * delta;
    assign fsum       = {{(FSUM_W-DATA_W){est_reg[DATA_W-1]}}, est_reg}
                      + {fprod_reg[FPROD_W-1], fprod_reg[FPROD_W-1:16]};
    assign est_next   = sat_fsum(fsum);

    // divider operands
    assign div_load = ctrl.run && (ctrl.op == OP_LOAD_T || ctrl.op == OP_LOAD_C);
    assign div_step = ctrl.run && (ctrl.op == OP_DIV);

    always_comb begin
        if (ctrl.op == OP_LOAD_T) begin
            div_num = DIV_NUM_W'(prod_reg);
            div_den = change_mag;
        end else if (cap_reg != '0) begin
            div_num = DIV_NUM_W'({cap_reg, 16'h0000});
            div_den = DIV_W'(dt_reg);
        end else begin
            div_num = DIV_NUM_W'({est_mag, 16'h0000});
            div_den = DIV_W'(dt_reg);
        end
    end

    sce_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (div_load),
        .step    (div_step),
        .num     (div_num),
        .den     (div_den),
        .quo     (div_quo),
        .ovf     (div_ovf),
        .last    (div_last)
    );

    // conductivity selection
    assign quo_sat31 = (div_ovf || div_quo[DIV_W-1]) ? MAX31 : div_quo[UDATA_W-1:0];

    always_comb begin
        if (dt_reg == '0) begin
            cond_next = min_cond_reg;
        end else if (cap_reg != '0) begin
            cond_next = quo_sat31;
        end else if (neg_reg) begin
            cond_next = min_cond_reg;
        end else begin
            cond_next = (quo_sat31 < min_cond_reg) ? min_cond_reg : quo_sat31;
        end
    end

    assign out_full = m_valid_reg && !m_ready;
    assign fin_fire = ctrl.run && (ctrl.op == OP_FINISH) && !out_full;

    // status to the sequencer
    always_comb begin
        status.update   = ({1'b0, change_mag} > {2'b00, min_dp_reg});
        status.dt_zero  = (dt_reg == '0);
        status.div_last = div_last;
        status.out_full = out_full;
    end

    // configuration, running state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cond_reg  <= '0;
            min_dp_reg    <= '0;
            gain_reg      <= '0;
            avg_dem_reg   <= '0;
            avg_press_reg <= '0;
            est_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MIN_COND: min_cond_reg <= cfg_wr_data;
                    CFG_MIN_DP:   min_dp_reg   <= cfg_wr_data;
                    CFG_GAIN:     gain_reg     <= cfg_wr_data[GAIN_W-1:0];
                    default:      ;
                endcase
            end
            if (ctrl.run && ctrl.op == OP_AVG) begin
                avg_dem_reg   <= avg_dem_next;
                avg_press_reg <= avg_press_next;
            end
            if (ctrl.run && ctrl.op == OP_FADD) begin
                est_reg <= est_next;
            end
            if (fin_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input capture and work registers
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            flux_reg  <= s_demand_flux;
            press_reg <= s_supply_pressure;
            dt_reg    <= s_time_step;
            cap_reg   <= s_given_capacitance;
        end
        if (ctrl.run) begin
            case (ctrl.op)
                OP_AVG:    change_reg <= change_next;
                OP_MUL:    prod_reg   <= prod_next;
                OP_LOAD_T: neg_reg    <= dem_pos ^ change_reg[DATA_W-1];
                OP_FMUL:   fprod_reg  <= fprod_next;
                OP_LOAD_C: neg_reg    <= (cap_reg == '0) && est_reg[DATA_W-1];
                default:   ;
            endcase
        end
        if (fin_fire) begin
            cond_reg       <= cond_next;
            est_out_reg    <= est_reg;
            change_out_reg <= change_reg;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_conductivity         = cond_reg;
    assign m_capacitance_estimate = est_out_reg;
    assign m_pressure_change      = change_out_reg;

    // a new result only comes from the final step
    `SCE_ASSERT_IMP(a_valid_source,
        m_valid_reg && !$past(m_valid_reg),
        $past(fin_fire),
        "result appeared without a final step")

endmodule

`default_nettype wire
